// ----- sv/rarp_pkg.sv -----
package rarp_pkg;

    localparam int RING_SIZE = 64;
    localparam int NUM_DCS   = 4;
    localparam int NUM_RACKS = 8;
    localparam int POS_W     = 6;
    localparam int LEN_W     = 7;
    localparam int HOST_W    = 8;
    localparam int ENTRY_W   = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 7;
    localparam int DC_W      = 2;
    localparam int RACK_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_RING_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DC0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DC3  = 3'd4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [POS_W-1:0]    position;
        logic [HOST_W-1:0]   host_id;
        logic                dc_present;
        logic [DC_W-1:0]     dc_index;
        logic                rack_present;
        logic [RACK_W-1:0]   rack_index;
    } in_req_t;

    typedef struct packed {
        logic [POS_W-1:0]    start_position;
        logic [HOST_W-1:0]   replica_host;
        logic [POS_W-1:0]    replica_position;
        logic                found;
        logic                last;
    } out_req_t;

    // decoded ring entry
    typedef struct packed {
        logic                dc_ok;
        logic [DC_W-1:0]     dc;
        logic                rack_ok;
        logic [RACK_W-1:0]   rack;
        logic [HOST_W-1:0]   host;
    } entry_t;

    function automatic entry_t decode_entry(input logic [ENTRY_W-1:0] e);
        entry_t d;
        d.host    = e[7:0];
        d.dc_ok   = e[8];
        d.dc      = e[10:9];
        d.rack_ok = e[11];
        d.rack    = e[14:12];
        return d;
    endfunction

endpackage

// ----- sv/rack_aware_replica_placement_top.sv -----
// Rack-aware replica placement. A write request (operation 0) stores one ring
// entry and the block is ready again on the next cycle. A query request reads the
// ring through the registered read port of the ring memory, with a read state and
// an evaluate state for each entry. First a counting lap over the first ring_length
// entries (at most RING_SIZE) learns the racks of each datacenter. Then at most one
// lap of placement runs from the start position. Each host drained from the skipped
// FIFO of a datacenter passes a FIFO read, a ring read and an evaluation step, and
// a closing step sends the final result. An empty ring or a bad start goes straight
// to the closing step. Each replica is held back one step so that the final one
// can carry last. The walk waits while the output register still holds a result
// that has not been taken. in_stall is high while a query runs and while a result
// waits.
module rack_aware_replica_placement_top
    import rarp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_req_t               in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_req_t              out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_CNT_RD, S_CNT_EV, S_WALK_RD, S_WALK_EV,
        S_DRN_RD, S_DRN_EN, S_DRN_EV, S_FINISH
    } state_t;

    state_t state_reg;

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] tgt_reg [NUM_DCS];

    logic [POS_W-1:0] start_reg, j_reg, p_reg;
    logic [LEN_W-1:0] step_reg;
    logic             any_reg;    // a replica is held in hold_reg
    logic [NUM_RACKS-1:0] mask_reg [NUM_DCS];
    logic [NUM_RACKS-1:0] seen_reg [NUM_DCS];
    logic [LEN_W-1:0] found_reg [NUM_DCS];
    logic [LEN_W-1:0] skc_reg [NUM_DCS];
    logic [POS_W-1:0] head_reg [NUM_DCS];
    logic [DC_W-1:0]  du_reg;
    logic             pend_reg;   // result waiting in out_data
    out_req_t         out_reg;
    out_req_t         hold_reg;

    logic [ENTRY_W-1:0] rdata;
    logic [POS_W-1:0]   raddr;
    logic [POS_W-1:0]   fifo_rdata;
    logic               fifo_we;
    logic [DC_W+POS_W-1:0] fifo_waddr, fifo_raddr;
    entry_t             ent;

    logic [LEN_W-1:0] len_eff;
    assign len_eff = (len_reg > LEN_W'(RING_SIZE)) ? LEN_W'(RING_SIZE) : len_reg;

    logic accept;
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || pend_reg;
    assign out_valid = pend_reg;
    assign out_data  = out_reg;

    assign ent = decode_entry(rdata);

    // ring memory address
    always_comb
    begin
        raddr = j_reg;
        if (state_reg == S_DRN_EN)
            raddr = fifo_rdata;
        else if (state_reg == S_DRN_EV)
            raddr = p_reg;
    end

    rarp_ring_mem u_ring (
        .clk   (clk),
        .we    (accept && in_data.operation == OP_WRITE),
        .waddr (in_data.position),
        .wdata ({in_data.rack_index, in_data.rack_present, in_data.dc_index,
                 in_data.dc_present, in_data.host_id}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign fifo_raddr = {du_reg, head_reg[du_reg]};

    rarp_fifo_mem u_fifo (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (j_reg),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    // walk evaluation for the current entry
    logic [LEN_W-1:0] tg;
    logic [3:0] seen_n, rin;
    logic       elig, take, park, newrack;
    logic [NUM_RACKS-1:0] seen_upd;
    logic [LEN_W-1:0] found_upd;
    logic       all_met_upd;
    logic [POS_W-1:0] j_nxt;

    always_comb
    begin
        tg = tgt_reg[ent.dc];
        seen_n = 4'($countones(seen_reg[ent.dc]));
        rin = 4'($countones(mask_reg[ent.dc]));
        elig = ent.dc_ok && (tg != '0) && (found_reg[ent.dc] < tg);
        take = elig && (!ent.rack_ok || seen_n == rin);
        newrack = elig && !take && !seen_reg[ent.dc][ent.rack];
        park = elig && !take && !newrack;
        fifo_we = (state_reg == S_WALK_EV) && park && (skc_reg[ent.dc] < LEN_W'(RING_SIZE));
        fifo_waddr = {ent.dc, POS_W'(head_reg[ent.dc] + POS_W'(skc_reg[ent.dc]))};
        seen_upd = seen_reg[ent.dc];
        if (newrack)
            seen_upd[ent.rack] = 1'b1;
        found_upd = found_reg[ent.dc] + LEN_W'(take || newrack);
        all_met_upd = 1'b1;
        for (int d = 0; d < NUM_DCS; d++)
        begin
            if (DC_W'(d) == ent.dc)
            begin
                if (found_upd < tgt_reg[d])
                    all_met_upd = 1'b0;
            end
            else if (found_reg[d] < tgt_reg[d])
                all_met_upd = 1'b0;
        end
        j_nxt = (LEN_W'(j_reg) + 1'b1 == len_eff) ? '0 : j_reg + 1'b1;
    end

    // drain evaluation after the current drained host
    logic drn_more, drn_met;
    always_comb
    begin
        drn_more = (skc_reg[du_reg] != '0)
                   && (found_reg[du_reg] + 1'b1 < tgt_reg[du_reg]);
        drn_met = 1'b1;
        for (int d = 0; d < NUM_DCS; d++)
        begin
            if (DC_W'(d) == du_reg)
            begin
                if (found_reg[d] + 1'b1 < tgt_reg[d])
                    drn_met = 1'b0;
            end
            else if (found_reg[d] < tgt_reg[d])
                drn_met = 1'b0;
        end
    end

    // output push: the held replica moves out when a newer one replaces it
    logic     out_free, ev_go, push;
    out_req_t push_data;
    always_comb
    begin
        out_free = !pend_reg || !out_stall;
        ev_go = out_free || !any_reg;
        push = 1'b0;
        push_data = hold_reg;
        if (state_reg == S_WALK_EV)
            push = ev_go && any_reg && (take || newrack);
        else if (state_reg == S_DRN_EV)
            push = ev_go && any_reg;
        else if (state_reg == S_FINISH)
        begin
            push = out_free;
            push_data.last = 1'b1;
            if (!any_reg)
                push_data = '{start_position: start_reg, replica_host: '0,
                              replica_position: '0, found: 1'b0, last: 1'b1};
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            for (int d = 0; d < NUM_DCS; d++)
                tgt_reg[d] <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_RING_LENGTH)
                len_reg <= cfg_data;
            else if (cfg_index >= REG_TARGET_DC0 && cfg_index <= REG_TARGET_DC3)
                tgt_reg[DC_W'(cfg_index - REG_TARGET_DC0)] <= cfg_data;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg <= 1'b0;
            any_reg <= 1'b0;
            out_reg <= '0;
            hold_reg <= '0;
            start_reg <= '0;
            j_reg <= '0;
            p_reg <= '0;
            step_reg <= '0;
            du_reg <= '0;
            for (int d = 0; d < NUM_DCS; d++)
            begin
                mask_reg[d] <= '0;
                seen_reg[d] <= '0;
                found_reg[d] <= '0;
                skc_reg[d] <= '0;
                head_reg[d] <= '0;
            end
        end
        else
        begin
            // output register
            if (push)
            begin
                out_reg <= push_data;
                pend_reg <= 1'b1;
            end
            else if (!out_stall)
                pend_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && in_data.operation == OP_QUERY)
                    begin
                        start_reg <= in_data.position;
                        any_reg <= 1'b0;
                        j_reg <= '0;
                        step_reg <= '0;
                        for (int d = 0; d < NUM_DCS; d++)
                        begin
                            mask_reg[d] <= '0;
                            seen_reg[d] <= '0;
                            found_reg[d] <= '0;
                            skc_reg[d] <= '0;
                            head_reg[d] <= '0;
                        end
                        if (len_eff == '0 || LEN_W'(in_data.position) >= len_eff)
                            state_reg <= S_FINISH;
                        else
                            state_reg <= S_CNT_RD;
                    end
                end
                S_CNT_RD:
                    state_reg <= S_CNT_EV;
                S_CNT_EV:
                begin
                    if (ent.dc_ok && ent.rack_ok)
                        mask_reg[ent.dc][ent.rack] <= 1'b1;
                    if (step_reg + 1'b1 == len_eff)
                    begin
                        step_reg <= '0;
                        j_reg <= start_reg;
                        state_reg <= S_WALK_RD;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                        j_reg <= j_reg + 1'b1;
                        state_reg <= S_CNT_RD;
                    end
                end
                S_WALK_RD:
                    state_reg <= S_WALK_EV;
                S_WALK_EV:
                begin
                    if (ev_go)
                    begin
                        du_reg <= ent.dc;
                        if (take || newrack)
                        begin
                            found_reg[ent.dc] <= found_upd;
                            seen_reg[ent.dc] <= seen_upd;
                            hold_reg <= '{start_position: start_reg, replica_host: ent.host,
                                          replica_position: j_reg, found: 1'b1, last: 1'b0};
                            any_reg <= 1'b1;
                        end
                        if (fifo_we)
                            skc_reg[ent.dc] <= skc_reg[ent.dc] + 1'b1;
                        step_reg <= step_reg + 1'b1;
                        j_reg <= j_nxt;
                        if (newrack && 4'($countones(seen_upd)) == rin
                            && skc_reg[ent.dc] != '0 && found_upd < tg)
                            state_reg <= S_DRN_RD;
                        else if ((elig && all_met_upd) || step_reg + 1'b1 == len_eff)
                            state_reg <= S_FINISH;
                        else
                            state_reg <= S_WALK_RD;
                    end
                end
                S_DRN_RD:
                    // fifo head read in flight
                    state_reg <= S_DRN_EN;
                S_DRN_EN:
                begin
                    p_reg <= fifo_rdata;
                    head_reg[du_reg] <= head_reg[du_reg] + 1'b1;
                    skc_reg[du_reg] <= skc_reg[du_reg] - 1'b1;
                    state_reg <= S_DRN_EV;
                end
                S_DRN_EV:
                begin
                    if (ev_go)
                    begin
                        found_reg[du_reg] <= found_reg[du_reg] + 1'b1;
                        hold_reg <= '{start_position: start_reg, replica_host: ent.host,
                                      replica_position: p_reg, found: 1'b1, last: 1'b0};
                        any_reg <= 1'b1;
                        if (drn_more)
                            state_reg <= S_DRN_RD;
                        else if (step_reg == len_eff || drn_met)
                            state_reg <= S_FINISH;
                        else
                            state_reg <= S_WALK_RD;
                    end
                end
                S_FINISH:
                begin
                    // final replica or empty placement goes out with last
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("request taken while busy");
    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (found_reg[0] <= tgt_reg[0]))
        else $error("dc0 over target");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped");
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_data))
        else $error("stalled result changed");
`endif

endmodule

// ----- sv/rarp_ring_mem.sv -----
module rarp_ring_mem
    import rarp_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [POS_W-1:0]   waddr,
    input  logic [ENTRY_W-1:0] wdata,
    input  logic [POS_W-1:0]   raddr,
    output logic [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [RING_SIZE];

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/rarp_fifo_mem.sv -----
module rarp_fifo_mem
    import rarp_pkg::*;
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [DC_W+POS_W-1:0] waddr,
    input  logic [POS_W-1:0]      wdata,
    input  logic [DC_W+POS_W-1:0] raddr,
    output logic [POS_W-1:0]      rdata
);

    // skipped positions, one region of RING_SIZE per datacenter
    logic [POS_W-1:0] mem [NUM_DCS*RING_SIZE];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import rarp_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int CYCLE_CAP  = 600000;
    localparam int HOLD_LEN   = 400;
    localparam int SETTLE_CYC = 12;

    // one line of the directed table: a register write or a request
    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        in_req_t               req;
        bit                    fixed;
        out_req_t              fixed_res;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_req_t               in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_req_t              out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // placement model state
    entry_t                ring_tab [RING_SIZE];
    logic [LEN_W-1:0]      ring_len_reg;
    logic [CFG_DATA_W-1:0] dc_goal [NUM_DCS];
    out_req_t              replica_q [$];
    dir_row_t              dir_tab [$];

    int  errors = 0;
    int  n_queries = 0;
    int  n_writes = 0;
    int  n_results = 0;
    int  n_cycles = 0;
    int  burst_left = 0;
    bit  hold_req = 1'b0;

    rack_aware_replica_placement_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d results pending", n_cycles,
                     replica_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 n_cycles);
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_req_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (replica_q.size() == 0)
            begin
                report("unexpected result, host", out_data.replica_host, -1);
            end
            else
            begin
                want = replica_q[0];
                replica_q.delete(0);
                if (out_data.start_position !== want.start_position)
                    report("start_position", out_data.start_position, want.start_position);
                if (out_data.replica_host !== want.replica_host)
                    report("replica_host", out_data.replica_host, want.replica_host);
                if (out_data.replica_position !== want.replica_position)
                    report("replica_position", out_data.replica_position,
                           want.replica_position);
                if (out_data.found !== want.found)
                    report("found", out_data.found, want.found);
                if (out_data.last !== want.last)
                    report("last", out_data.last, want.last);
            end
        end
    end

    // receiver stall pattern, with an occasional long hold
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(16, 80);
                end
                left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // expected replicas of one query, appended to replica_q
    function automatic void plan_placement(input logic [POS_W-1:0] start);
        int         len;
        int         n;
        int         j;
        int         p;
        int         du;
        int         racks_tot [NUM_DCS];
        int         got [NUM_DCS];
        int         park_head [NUM_DCS];
        int         park_cnt [NUM_DCS];
        int         parked [NUM_DCS][RING_SIZE];
        logic [7:0] rack_mask [NUM_DCS];
        logic [7:0] seen [NUM_DCS];
        bit         met;
        entry_t     e;
        out_req_t   r;

        len = (ring_len_reg > RING_SIZE) ? RING_SIZE : ring_len_reg;
        n = 0;
        r = '0;
        r.start_position = start;
        if (len != 0 && start < len)
        begin
            for (int d = 0; d < NUM_DCS; d++)
            begin
                rack_mask[d] = '0;
                seen[d] = '0;
                got[d] = 0;
                park_head[d] = 0;
                park_cnt[d] = 0;
            end
            for (int k = 0; k < len; k++)
                if (ring_tab[k].dc_ok && ring_tab[k].rack_ok)
                    rack_mask[ring_tab[k].dc][ring_tab[k].rack] = 1'b1;
            for (int d = 0; d < NUM_DCS; d++)
                racks_tot[d] = $countones(rack_mask[d]);

            j = start;
            r.found = 1'b1;
            for (int step = 0; step < len; step++)
            begin
                e = ring_tab[j];
                du = e.dc;
                if (e.dc_ok && dc_goal[du] > 0 && got[du] < dc_goal[du])
                begin
                    if (!e.rack_ok || $countones(seen[du]) == racks_tot[du])
                    begin
                        r.replica_host = e.host;
                        r.replica_position = POS_W'(j);
                        replica_q.insert(replica_q.size(), r);
                        n++;
                        got[du]++;
                    end
                    else if (seen[du][e.rack])
                    begin
                        // rack already used: park for later
                        if (park_cnt[du] < RING_SIZE)
                        begin
                            parked[du][(park_head[du] + park_cnt[du]) % RING_SIZE] = j;
                            park_cnt[du]++;
                        end
                    end
                    else
                    begin
                        r.replica_host = e.host;
                        r.replica_position = POS_W'(j);
                        replica_q.insert(replica_q.size(), r);
                        n++;
                        got[du]++;
                        seen[du][e.rack] = 1'b1;
                        // all racks seen: drain parked hosts
                        if ($countones(seen[du]) == racks_tot[du])
                        begin
                            while (park_cnt[du] > 0 && got[du] < dc_goal[du])
                            begin
                                p = parked[du][park_head[du]];
                                park_head[du] = (park_head[du] + 1) % RING_SIZE;
                                park_cnt[du]--;
                                r.replica_host = ring_tab[p].host;
                                r.replica_position = POS_W'(p);
                                replica_q.insert(replica_q.size(), r);
                                n++;
                                got[du]++;
                            end
                        end
                    end
                    met = 1'b1;
                    for (int d = 0; d < NUM_DCS; d++)
                        if (got[d] < dc_goal[d])
                            met = 1'b0;
                    if (met)
                        break;
                end
                j = (j + 1 == len) ? 0 : j + 1;
            end
        end
        if (n == 0)
        begin
            r = '0;
            r.start_position = start;
            replica_q.insert(replica_q.size(), r);
        end
        replica_q[replica_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void apply_req(input in_req_t q);
        if (q.operation == OP_WRITE)
        begin
            n_writes++;
            ring_tab[q.position].host    = q.host_id;
            ring_tab[q.position].dc_ok   = q.dc_present;
            ring_tab[q.position].dc      = q.dc_index;
            ring_tab[q.position].rack_ok = q.rack_present;
            ring_tab[q.position].rack    = q.rack_index;
        end
        else
        begin
            n_queries++;
            plan_placement(q.position);
        end
    endfunction

    function automatic in_req_t mk_req(input logic op, input int pos, input int host,
                                       input logic dcp, input int dc, input logic rkp,
                                       input int rk);
        in_req_t q;
        q.operation    = op;
        q.position     = POS_W'(pos);
        q.host_id      = HOST_W'(host);
        q.dc_present   = dcp;
        q.dc_index     = DC_W'(dc);
        q.rack_present = rkp;
        q.rack_index   = RACK_W'(rk);
        return q;
    endfunction

    // random entry shaped so that racks repeat and the parking path is hit
    function automatic in_req_t rand_write(input int pos);
        int dc;
        int rk;
        dc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 1);
        rk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
        return mk_req(OP_WRITE, pos, $urandom_range(0, 255), $urandom_range(0, 9) != 0,
                      dc, $urandom_range(0, 4) != 0, rk);
    endfunction

    function automatic in_req_t rand_query();
        int len;
        int pos;
        len = (ring_len_reg > RING_SIZE) ? RING_SIZE : ring_len_reg;
        if (len > 0 && $urandom_range(0, 3) != 0)
            pos = $urandom_range(0, len - 1);
        else
            pos = $urandom_range(0, RING_SIZE - 1);
        return mk_req(OP_QUERY, pos, $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 3), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 7));
    endfunction

    // offer one request until taken, with bursts and gaps on the sender side
    task automatic drive_req(input in_req_t q);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= q;
        do @(posedge clk); while (in_stall);
    endtask

    // send one request and predict its results
    task automatic send_req(input in_req_t q);
        drive_req(q);
        apply_req(q);
    endtask

    // stop sending and wait for every pending result, then let writes settle
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (replica_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(posedge clk);
        if (idx == REG_RING_LENGTH)
            ring_len_reg = LEN_W'(val);
        else
            dc_goal[idx - REG_TARGET_DC0] = CFG_DATA_W'(val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input int len, input int t0, input int t1, input int t2,
                            input int t3);
        drain();
        write_reg(REG_RING_LENGTH, len);
        write_reg(REG_TARGET_DC0, t0);
        write_reg(REG_TARGET_DC0 + 1, t1);
        write_reg(REG_TARGET_DC0 + 2, t2);
        write_reg(REG_TARGET_DC3, t3);
    endtask

    function automatic void add_row(input bit is_reg, input int idx, input int val,
                                    input in_req_t q, input bit fixed, input int fpos);
        dir_row_t row;
        row.is_reg = is_reg;
        row.reg_idx = CFG_IDX_W'(idx);
        row.reg_val = CFG_DATA_W'(val);
        row.req = q;
        row.fixed = fixed;
        row.fixed_res = '0;
        row.fixed_res.start_position = POS_W'(fpos);
        row.fixed_res.last = 1'b1;
        dir_tab.insert(dir_tab.size(), row);
    endfunction

    // main sequence
    initial
    begin
        in_req_t none;
        none = '0;
        ring_len_reg = '0;
        for (int d = 0; d < NUM_DCS; d++)
            dc_goal[d] = '0;
        for (int k = 0; k < RING_SIZE; k++)
            ring_tab[k] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; fixed rows expect the empty placement
        add_row(0, 0, 0, mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0), 1, 0);
        add_row(0, 0, 0, mk_req(OP_WRITE, 0, 255, 1, 0, 1, 0), 0, 0);
        add_row(0, 0, 0, mk_req(OP_WRITE, 1, 0, 1, 0, 1, 0), 0, 0);
        add_row(0, 0, 0, mk_req(OP_WRITE, 2, 17, 0, 0, 1, 7), 0, 0);
        add_row(0, 0, 0, mk_req(OP_WRITE, 3, 3, 1, 0, 1, 1), 0, 0);
        add_row(0, 0, 0, mk_req(OP_WRITE, 4, 4, 1, 1, 0, 0), 0, 0);
        add_row(0, 0, 0, mk_req(OP_WRITE, 5, 5, 1, 1, 0, 0), 0, 0);
        add_row(0, 0, 0, mk_req(OP_WRITE, 6, 6, 1, 0, 1, 2), 0, 0);
        add_row(0, 0, 0, mk_req(OP_WRITE, 7, 7, 1, 3, 1, 5), 0, 0);
        add_row(0, 0, 0, mk_req(OP_WRITE, 63, 255, 1, 3, 1, 7), 0, 0);
        add_row(1, REG_RING_LENGTH, 8, none, 0, 0);
        add_row(0, 0, 0, mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0), 1, 0);
        add_row(1, REG_TARGET_DC0, 3, none, 0, 0);
        add_row(0, 0, 0, mk_req(OP_QUERY, 0, 0, 0, 0, 0, 0), 0, 0);
        add_row(0, 0, 0, mk_req(OP_QUERY, 5, 0, 0, 0, 0, 0), 0, 0);
        add_row(0, 0, 0, mk_req(OP_QUERY, 8, 0, 0, 0, 0, 0), 1, 8);
        add_row(1, REG_TARGET_DC0 + 1, 64, none, 0, 0);
        add_row(1, REG_TARGET_DC0 + 2, 1, none, 0, 0);
        add_row(0, 0, 0, mk_req(OP_QUERY, 7, 0, 0, 0, 0, 0), 0, 0);
        add_row(1, REG_TARGET_DC0, 64, none, 0, 0);
        add_row(1, REG_TARGET_DC3, 1, none, 0, 0);
        add_row(0, 0, 0, mk_req(OP_QUERY, 63, 0, 0, 0, 0, 0), 1, 63);
        add_row(0, 0, 0, mk_req(OP_QUERY, 1, 0, 0, 0, 0, 0), 0, 0);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_reg)
            begin
                drain();
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end
            else if (dir_tab[i].fixed)
            begin
                drive_req(dir_tab[i].req);
                n_queries++;
                replica_q.insert(replica_q.size(), dir_tab[i].fixed_res);
            end
            else
            begin
                send_req(dir_tab[i].req);
            end
        end

        // fill the whole ring with random entries, small ring queried meanwhile
        set_regs(8, 2, 1, 0, 1);
        for (int k = 0; k < RING_SIZE; k++)
        begin
            send_req(rand_write(k));
            if ($urandom_range(0, 3) == 0)
                send_req(rand_query());
            if (k == RING_SIZE / 2)
                drain();
        end

        // several register settings, extremes among them
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_regs(100, 64, 64, 64, 64);
                1: set_regs(64, $urandom_range(1, 4), $urandom_range(1, 4),
                            $urandom_range(1, 4), $urandom_range(1, 4));
                2: set_regs(1, 1, 0, 0, 0);
                3: set_regs($urandom_range(2, 20), $urandom_range(0, 3),
                            $urandom_range(0, 3), $urandom_range(0, 3),
                            $urandom_range(0, 3));
                4: set_regs(0, $urandom_range(0, 64), $urandom_range(0, 64),
                            $urandom_range(0, 64), $urandom_range(0, 64));
                default: set_regs(64, 3, 64, 0, 2);
            endcase
            if (ph == 0)
                hold_req = 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                if ($urandom_range(0, 5) == 0)
                    send_req(rand_write($urandom_range(0, RING_SIZE - 1)));
                else
                    send_req(rand_query());
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d ring writes and %0d placement queries, %0d replicas checked",
                 n_writes, n_queries, n_results);
        $display("ring lengths 0 to saturated, targets 0 to 64, long output hold included");
        if (errors == 0 && replica_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
